[src/ssef_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the Sobel sum edge filter.
// No dependencies; imported by ssef_col_cell, ssef_raster_ctl and the filter top.
package ssef_pkg;

   localparam int PIXEL_BITS     = 8;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int CFG_BITS       = 11;
   localparam int ROW_BITS       = 11;
   localparam int HEIGHT_LIMIT   = 1024;
   localparam int WIDTH_RESET    = 640;
   localparam int HEIGHT_RESET   = 480;
   localparam int CSR_INDEX_BITS = 4;
   localparam int DIFF_BITS      = 11;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_BITS'(1);

   typedef logic [PIXEL_BITS-1:0] pix_type;

   typedef struct packed {
      pix_type top;
      pix_type mid;
      pix_type bot;
   } col_type;

   typedef struct packed {
      pix_type upper;
      pix_type middle;
   } line_type;

   typedef struct packed {
      logic c0;
      logic pix_ok;
      logic up_ok;
      logic mid_ok;
      logic valid;
      logic last;
   } pos_type;

endpackage

[src/ssef_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssef_ram #(
   parameter int Width = 16,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/ssef_col_cell.sv]
`timescale 1ns / 1ps
// One window column cell: holds three pixels, loads its neighbor's column.
// Depends on ssef_pkg.
module ssef_col_cell
   import ssef_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    zero_load,
   input  col_type col_in,
   output col_type col_out
);

   col_type col_ff;
   col_type col_nx_in;

   always_comb begin
      col_nx_in = col_ff;
      if (advance) begin
         col_nx_in = zero_load ? '0 : col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_nx_in;
      end
   end

   assign col_out = col_ff;

endmodule

[src/ssef_raster_ctl.sv]
`timescale 1ns / 1ps
// Frame size registers and raster position counters with per-word flags.
// Depends on ssef_pkg.
module ssef_raster_ctl
   import ssef_pkg::*;
#(
   parameter int MaxWidth = MAX_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cfg_wr,
   input  logic [CSR_INDEX_BITS-1:0]   cfg_index,
   input  logic [CFG_BITS-1:0]         cfg_data,
   input  logic                        step,
   input  logic                        kind,
   output logic [$clog2(MaxWidth)-1:0] col_addr,
   output pos_type                     pos
);

   localparam int CW = $clog2(MaxWidth);
   localparam int WB = $clog2(MaxWidth + 1);

   logic [CFG_BITS-1:0] width_ff, width_in;
   logic [CFG_BITS-1:0] height_ff, height_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;

   logic [WB-1:0]       eff_w;
   logic [ROW_BITS-1:0] eff_h;
   logic [ROW_BITS-1:0] h_p1;
   logic [CW-1:0]       c_cur;
   logic [ROW_BITS-1:0] r_cur;
   logic [WB-1:0]       c_nx;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = WB'(1);
      end else if (32'(width_ff) > 32'(MaxWidth)) begin
         eff_w = WB'(MaxWidth);
      end else begin
         eff_w = WB'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = ROW_BITS'(1);
      end else if (32'(height_ff) > 32'(HEIGHT_LIMIT)) begin
         eff_h = ROW_BITS'(HEIGHT_LIMIT);
      end else begin
         eff_h = ROW_BITS'(height_ff);
      end
      h_p1  = eff_h + ROW_BITS'(1);
      c_cur = (WB'(col_ff) >= eff_w) ? '0 : col_ff;
      r_cur = ({1'b0, row_ff} > {1'b0, h_p1}) ? '0 : row_ff;
      c_nx  = WB'(c_cur) + WB'(1);
   end

   always_comb begin
      pos.c0     = (c_cur == '0);
      pos.pix_ok = !kind && (r_cur < eff_h);
      pos.up_ok  = (r_cur >= ROW_BITS'(2));
      pos.mid_ok = (r_cur != '0);
      pos.valid  = pos.c0 ? ((r_cur >= ROW_BITS'(2)) && (r_cur <= h_p1))
                          : ((r_cur != '0) && (r_cur <= eff_h));
      pos.last   = pos.c0 && (r_cur == h_p1);
   end

   assign col_addr = c_cur;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (cfg_wr && (cfg_index == CSR_IMAGE_WIDTH || cfg_index == CSR_IMAGE_HEIGHT)) begin
         if (cfg_index == CSR_IMAGE_WIDTH) begin
            width_in = cfg_data;
         end else begin
            height_in = cfg_data;
         end
         col_in = '0;
         row_in = '0;
      end else if (step) begin
         if (pos.last) begin
            col_in = '0;
            row_in = '0;
         end else if (c_nx >= eff_w) begin
            col_in = '0;
            row_in = r_cur + ROW_BITS'(1);
         end else begin
            col_in = CW'(c_nx);
            row_in = r_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_BITS'(WIDTH_RESET);
         height_ff <= CFG_BITS'(HEIGHT_RESET);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

[src/sobel_sum_edge_filter.sv]
`timescale 1ns / 1ps
// Sobel sum edge filter: 3x3 window over a pixel stream, output gx + gy clamped.
// Words pass the sa stage and output register; 1 word/cycle unless rsp_stall holds.
// Rate is set by the line store RAM: one read and one write per column each cycle.
// Reset: synchronous; clears counters, window cells, pipeline valids, and sets
// width 640, height 480. Line store contents are not cleared (row gating hides them).
// Depends on ssef_pkg, ssef_ram, ssef_col_cell, ssef_raster_ctl.
module sobel_sum_edge_filter
   import ssef_pkg::*;
#(
   parameter int MaxWidth = MAX_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_kind,
   input  logic [PIXEL_BITS-1:0]     req_pixel_in,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [PIXEL_BITS-1:0]     rsp_pixel_out,
   output logic                      rsp_frame_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata
);

   localparam int CW = $clog2(MaxWidth);

   logic          accept;
   logic          advance;
   logic [CW-1:0] col_addr;
   pos_type       pos;

   logic          sa_vld_ff, sa_vld_in;
   pos_type       sa_pos_ff;
   logic [CW-1:0] sa_addr_ff;
   pix_type       sa_pix_ff;
   logic          fwd_ff;
   line_type      fwd_data_ff;
   line_type      ram_q;
   line_type      rd_line;
   line_type      wr_line;
   logic          wr_en;

   col_type       new_col;
   col_type       mid_col;
   col_type       right_col;

   logic [PIXEL_BITS+1:0] pos_sum;
   logic [PIXEL_BITS+1:0] neg_sum;
   logic signed [DIFF_BITS-1:0] diff;
   pix_type       edge_val;

   logic          rsp_valid_ff, rsp_valid_in;
   pix_type       rsp_pixel_ff;
   logic          rsp_last_ff;

   assign csr_ready = 1'b1;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = sa_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign wr_en     = sa_vld_ff && advance;

   ssef_raster_ctl #(
      .MaxWidth (MaxWidth)
   ) u_ctl (
      .clock     (clock),
      .reset     (reset),
      .cfg_wr    (csr_valid && csr_ready),
      .cfg_index (csr_index),
      .cfg_data  (csr_wdata),
      .step      (accept),
      .kind      (req_kind),
      .col_addr  (col_addr),
      .pos       (pos)
   );

   ssef_ram #(
      .Width ($bits(line_type)),
      .Depth (MaxWidth)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (sa_addr_ff),
      .wr_data (wr_line),
      .rd_en   (accept),
      .rd_addr (col_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      sa_vld_in = sa_vld_ff;
      if (accept) begin
         sa_vld_in = 1'b1;
      end else if (advance) begin
         sa_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_vld_ff <= 1'b0;
      end else begin
         sa_vld_ff <= sa_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sa_pos_ff   <= pos;
         sa_addr_ff  <= col_addr;
         sa_pix_ff   <= req_pixel_in;
         fwd_ff      <= wr_en && (sa_addr_ff == col_addr);
         fwd_data_ff <= wr_line;
      end
   end

   always_comb begin
      rd_line        = fwd_ff ? fwd_data_ff : ram_q;
      new_col.top    = sa_pos_ff.up_ok  ? rd_line.upper  : '0;
      new_col.mid    = sa_pos_ff.mid_ok ? rd_line.middle : '0;
      new_col.bot    = sa_pos_ff.pix_ok ? sa_pix_ff      : '0;
      wr_line.upper  = new_col.mid;
      wr_line.middle = new_col.bot;
   end

   ssef_col_cell u_cell_right (
      .clock     (clock),
      .reset     (reset),
      .advance   (wr_en),
      .zero_load (1'b0),
      .col_in    (new_col),
      .col_out   (right_col)
   );

   ssef_col_cell u_cell_mid (
      .clock     (clock),
      .reset     (reset),
      .advance   (wr_en),
      .zero_load (sa_pos_ff.c0),
      .col_in    (right_col),
      .col_out   (mid_col)
   );

   // gx + gy reduces to 2 * (w5 + w7 + w8 - w0 - w1 - w3)
   always_comb begin
      pos_sum = (PIXEL_BITS+2)'(right_col.bot);
      if (!sa_pos_ff.c0) begin
         pos_sum = pos_sum + (PIXEL_BITS+2)'(new_col.mid) + (PIXEL_BITS+2)'(new_col.bot);
      end
      neg_sum = (PIXEL_BITS+2)'(mid_col.top) + (PIXEL_BITS+2)'(mid_col.mid)
              + (PIXEL_BITS+2)'(right_col.top);
      diff = signed'(DIFF_BITS'(pos_sum)) - signed'(DIFF_BITS'(neg_sum));
      if (diff <= 0) begin
         edge_val = '0;
      end else if (diff >= DIFF_BITS'(128)) begin
         edge_val = '1;
      end else begin
         edge_val = {diff[PIXEL_BITS-2:0], 1'b0};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = sa_vld_ff && sa_pos_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pixel_ff <= edge_val;
         rsp_last_ff  <= sa_pos_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule
